>>> sv/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types, widths and register codes for the motor speed loop.
// ----------------------------------------------------------------------------
package msl_pkg;

  // Field widths
  localparam int SPD_W      = 20;   // signed Q16.4 speed
  localparam int POS_W      = 32;   // encoder position
  localparam int DUTY_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int KI_W       = 24;
  localparam int PLIM_W     = 19;
  localparam int INT_W      = 40;   // integral, 23 fraction bits
  localparam int FRAC_BITS  = 23;

  // Shared multiplier
  localparam int MUL_W      = 24;
  localparam int PROD_W     = 2 * MUL_W;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [GAIN_W-1:0] KP_RST        = 16'd461;
  localparam logic [KI_W-1:0]   KI_RST        = 24'd23488;
  localparam logic [DUTY_W-1:0] DUTY_LIM_RST  = 16'd1000;
  localparam logic [GAIN_W-1:0] ACCEL_RST     = 16'd16;
  localparam logic [GAIN_W-1:0] DECEL_RST     = 16'd16;
  localparam logic [GAIN_W-1:0] KPOS_RST      = 16'd256;
  localparam logic [PLIM_W-1:0] POS_LIM_RST   = 19'd16000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_DUTY_LIM  = 3'd2,
    REG_ACCEL     = 3'd3,
    REG_DECEL     = 3'd4,
    REG_KPOS      = 3'd5,
    REG_POS_LIM   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                     position_mode;
    logic signed [SPD_W-1:0]  speed_target;
    logic signed [POS_W-1:0]  goal_position;
    logic signed [POS_W-1:0]  current_position;
    logic signed [SPD_W-1:0]  measured_speed;
    logic                     clear_integral;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]        forward_duty;
    logic [DUTY_W-1:0]        reverse_duty;
    logic                     driver_enable;
    logic signed [SPD_W-1:0]  current_setpoint;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]     index;
    logic [CFG_DATA_W-1:0]    data;
  } cfg_beat_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [KI_W-1:0]   ki;
    logic [DUTY_W-1:0] duty_limit;
    logic [GAIN_W-1:0] accel;
    logic [GAIN_W-1:0] decel;
    logic [GAIN_W-1:0] kpos;
    logic [PLIM_W-1:0] pos_limit;
  } cfg_regs_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic pos_lo;     // low partial product of position error
    logic pos_hi;     // high partial product of position error
    logic pos_cmd;    // combine, scale and clamp position command
    logic ramp;       // step the setpoint
    logic err;        // speed error
    logic mul_ki;     // ki * |err|
    logic integ;      // integral update, kp * |err|
    logic pi;         // PI sum and clamp
    logic out_load;   // fill output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_pos_mode;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> sv/msl_if.sv
// ----------------------------------------------------------------------------
// msl_if
// Valid/ready channels of the motor speed loop: input, result and config.
// ----------------------------------------------------------------------------
interface msl_in_if import msl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface msl_out_if import msl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface msl_cfg_if import msl_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/msl_cfg.sv
// ----------------------------------------------------------------------------
// msl_cfg
// Configuration register file; always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module msl_cfg import msl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cfg_beat_t wr_beat,
  output cfg_regs_t regs
);

  cfg_regs_t regs_r;

  assign wr_ready = 1'b1;
  assign regs     = regs_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.kp         <= KP_RST;
      regs_r.ki         <= KI_RST;
      regs_r.duty_limit <= DUTY_LIM_RST;
      regs_r.accel      <= ACCEL_RST;
      regs_r.decel      <= DECEL_RST;
      regs_r.kpos       <= KPOS_RST;
      regs_r.pos_limit  <= POS_LIM_RST;
    end else if (wr_valid) begin
      case (wr_beat.index)
        REG_KP:       regs_r.kp         <= wr_beat.data[GAIN_W-1:0];
        REG_KI:       regs_r.ki         <= wr_beat.data[KI_W-1:0];
        REG_DUTY_LIM: regs_r.duty_limit <= wr_beat.data[DUTY_W-1:0];
        REG_ACCEL:    regs_r.accel      <= wr_beat.data[GAIN_W-1:0];
        REG_DECEL:    regs_r.decel      <= wr_beat.data[GAIN_W-1:0];
        REG_KPOS:     regs_r.kpos       <= wr_beat.data[GAIN_W-1:0];
        REG_POS_LIM:  regs_r.pos_limit  <= wr_beat.data[PLIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/msl_ctrl.sv
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer for one control tick: position command (position mode only), ramp, PI, output.
// ----------------------------------------------------------------------------
module msl_ctrl import msl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_LO,
    S_POS_HI,
    S_POS_CMD,
    S_RAMP,
    S_ERR,
    S_MUL_KI,
    S_INTEG,
    S_PI,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_pos_mode ? S_POS_LO : S_RAMP;
        end
      end
      S_POS_LO: begin
        cmd.pos_lo = 1'b1;
        state_nxt  = S_POS_HI;
      end
      S_POS_HI: begin
        cmd.pos_hi = 1'b1;
        state_nxt  = S_POS_CMD;
      end
      S_POS_CMD: begin
        cmd.pos_cmd = 1'b1;
        state_nxt   = S_RAMP;
      end
      S_RAMP: begin
        cmd.ramp  = 1'b1;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = S_MUL_KI;
      end
      S_MUL_KI: begin
        cmd.mul_ki = 1'b1;
        state_nxt  = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = S_PI;
      end
      S_PI: begin
        cmd.pi    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/msl_dp.sv
// ----------------------------------------------------------------------------
// msl_dp
// Datapath: one shared 24x24 multiplier, ramp, integral, PI clamp and the
// output register.
// ----------------------------------------------------------------------------
module msl_dp import msl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  cfg_regs_t regs,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int POS_SHIFT = 4;                 // Q.8 -> Q.4
  localparam int KI_SHIFT  = 5;                 // Q.28 -> Q.23
  localparam int KP_SHIFT  = FRAC_BITS - 12;    // Q.12 -> Q.23
  localparam int ERR_W     = SPD_W + 1;
  localparam int POSQ_W    = PROD_W + 1 - POS_SHIFT;
  localparam int ISUM_W    = INT_W + 2;
  localparam int KP_PROD_W = SPD_W + GAIN_W;
  localparam int PI_W      = KP_PROD_W + KP_SHIFT + 3;
  localparam int STEP_W    = ISUM_W - 1;

  // State and working registers
  logic                    mode_r;
  logic signed [SPD_W-1:0] meas_r;
  logic                    perr_neg_r;
  logic [POS_W-1:0]        perr_mag_r;
  logic [PROD_W-1:0]       acc_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [SPD_W-1:0] cmd_r;
  logic signed [SPD_W-1:0] ramp_r;
  logic                    err_neg_r;
  logic [SPD_W-1:0]        err_mag_r;
  logic signed [INT_W-1:0] int_r;
  logic signed [INT_W-1:0] pi_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  assign stat.in_pos_mode = in_item.position_mode;
  assign stat.out_busy    = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_item         = out_r;

  // Position error, sign and magnitude
  logic signed [POS_W:0] perr;
  logic [POS_W:0]        perr_abs;
  assign perr     = $signed({in_item.goal_position[POS_W-1], in_item.goal_position})
                  - $signed({in_item.current_position[POS_W-1], in_item.current_position});
  assign perr_abs = perr[POS_W] ? 33'(-perr) : 33'(perr);

  // Shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.pos_lo) begin
      mul_a = perr_mag_r[MUL_W-1:0];
      mul_b = MUL_W'(regs.kpos);
    end else if (cmd.pos_hi) begin
      mul_a = MUL_W'(perr_mag_r[POS_W-1:MUL_W]);
      mul_b = MUL_W'(regs.kpos);
    end else if (cmd.mul_ki) begin
      mul_a = MUL_W'(err_mag_r);
      mul_b = regs.ki;
    end else if (cmd.integ) begin
      mul_a = MUL_W'(err_mag_r);
      mul_b = MUL_W'(regs.kp);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Position command: combine partial products, scale, clamp
  logic [PROD_W:0]         pos_sum;
  logic [POSQ_W-1:0]       pos_q;
  logic [PLIM_W-1:0]       pos_mag;
  logic signed [SPD_W-1:0] pos_cmd;
  assign pos_sum = {1'b0, acc_r}
                 + {1'b0, prod_r[PROD_W-MUL_W-1:0], {MUL_W{1'b0}}};
  assign pos_q   = pos_sum[PROD_W:POS_SHIFT];
  assign pos_mag = (pos_q > POSQ_W'(regs.pos_limit)) ? regs.pos_limit
                                                    : pos_q[PLIM_W-1:0];
  assign pos_cmd = perr_neg_r ? -$signed({1'b0, pos_mag}) : $signed({1'b0, pos_mag});

  // Ramp toward the command without overshoot
  logic signed [SPD_W:0]   r_ext, c_ext, r_up, r_dn;
  logic signed [SPD_W-1:0] ramp_nxt;
  assign r_ext = {ramp_r[SPD_W-1], ramp_r};
  assign c_ext = {cmd_r[SPD_W-1], cmd_r};
  assign r_up  = r_ext + $signed({{(ERR_W-GAIN_W){1'b0}}, regs.accel});
  assign r_dn  = r_ext - $signed({{(ERR_W-GAIN_W){1'b0}}, regs.decel});
  always_comb begin
    ramp_nxt = ramp_r;
    if (r_ext < c_ext) begin
      ramp_nxt = (r_up > c_ext) ? cmd_r : r_up[SPD_W-1:0];
    end else if (r_ext > c_ext) begin
      ramp_nxt = (r_dn < c_ext) ? cmd_r : r_dn[SPD_W-1:0];
    end
  end

  // Speed error
  logic signed [ERR_W-1:0] err_s;
  logic [ERR_W-1:0]        err_abs;
  assign err_s   = $signed({ramp_r[SPD_W-1], ramp_r}) - $signed({meas_r[SPD_W-1], meas_r});
  assign err_abs = err_s[ERR_W-1] ? ERR_W'(-err_s) : ERR_W'(err_s);

  // Integral step and clamp
  logic signed [ISUM_W-1:0] step_ext, step_s, isum, ilim;
  logic signed [INT_W-1:0]  int_nxt;
  assign step_ext = $signed({1'b0, prod_r[STEP_W+KI_SHIFT-1:KI_SHIFT]});
  assign step_s   = err_neg_r ? -step_ext : step_ext;
  assign isum     = $signed({{(ISUM_W-INT_W){int_r[INT_W-1]}}, int_r}) + step_s;
  assign ilim     = $signed({{(ISUM_W-DUTY_W-FRAC_BITS){1'b0}}, regs.duty_limit,
                              {FRAC_BITS{1'b0}}});
  always_comb begin
    if (isum > ilim) begin
      int_nxt = ilim[INT_W-1:0];
    end else if (isum < -ilim) begin
      int_nxt = INT_W'(-ilim);
    end else begin
      int_nxt = isum[INT_W-1:0];
    end
  end

  // PI sum and clamp
  logic signed [PI_W-1:0] p_ext, p_s, pis, plim;
  logic signed [INT_W-1:0] pi_nxt;
  assign p_ext = $signed({3'b000, prod_r[KP_PROD_W-1:0], {KP_SHIFT{1'b0}}});
  assign p_s   = err_neg_r ? -p_ext : p_ext;
  assign pis   = p_s + $signed({{(PI_W-INT_W){int_r[INT_W-1]}}, int_r});
  assign plim  = $signed({{(PI_W-DUTY_W-FRAC_BITS){1'b0}}, regs.duty_limit,
                           {FRAC_BITS{1'b0}}});
  always_comb begin
    if (pis > plim) begin
      pi_nxt = plim[INT_W-1:0];
    end else if (pis < -plim) begin
      pi_nxt = INT_W'(-plim);
    end else begin
      pi_nxt = pis[INT_W-1:0];
    end
  end

  // Duty split, truncated toward zero
  logic [INT_W-1:0]  pi_abs;
  logic [DUTY_W-1:0] duty;
  out_item_t         out_nxt;
  assign pi_abs = pi_r[INT_W-1] ? INT_W'(-pi_r) : INT_W'(pi_r);
  assign duty   = pi_abs[FRAC_BITS+DUTY_W-1:FRAC_BITS];
  always_comb begin
    out_nxt.forward_duty     = pi_r[INT_W-1] ? '0 : duty;
    out_nxt.reverse_duty     = pi_r[INT_W-1] ? duty : '0;
    out_nxt.driver_enable    = (duty != '0);
    out_nxt.current_setpoint = ramp_r;
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_item.position_mode;
      meas_r     <= in_item.measured_speed;
      perr_neg_r <= perr[POS_W];
      perr_mag_r <= perr_abs[POS_W-1:0];
      cmd_r      <= in_item.speed_target;
    end
    if (cmd.pos_lo || cmd.pos_hi || cmd.mul_ki || cmd.integ) begin
      prod_r <= mul_p;
    end
    if (cmd.pos_hi) begin
      acc_r <= prod_r;
    end
    if (cmd.pos_cmd && mode_r) begin
      cmd_r <= pos_cmd;
    end
    if (cmd.err) begin
      err_neg_r <= err_s[ERR_W-1];
      err_mag_r <= err_abs[SPD_W-1:0];
    end
    if (cmd.pi) begin
      pi_r <= pi_nxt;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  // Loop state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r      <= '0;
      int_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ramp) begin
        ramp_r <= ramp_nxt;
      end
      if (cmd.load && in_item.clear_integral) begin
        int_r <= '0;
      end else if (cmd.integ) begin
        int_r <= int_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> sv/motor_speed_loop_pi_ramp_pwm_unit.sv
// ----------------------------------------------------------------------------
// motor_speed_loop_pi_ramp_pwm_unit
// Ramped PI speed loop with optional position command and signed PWM split.
//
//   channel | dir | payload                                    | handshake
//   --------+-----+--------------------------------------------+-----------
//   in_ch   | in  | mode, targets, positions, speed, clear     | valid/ready
//   out_ch  | out | forward/reverse duty, enable, setpoint     | valid/ready
//   cfg_ch  | in  | register index, write data                 | valid/ready
//
// Each tick is stepped by the sequencer through the shared 24x24 multiplier
// (two passes for the position error, one each for ki and kp). One tick is
// worked at a time; in_ready is high only while idle. The result sits in an
// output register, so the next beat is taken while it waits. Reset is
// synchronous, active low, and clears setpoint and integral; cfg writes are
// always accepted.
// ----------------------------------------------------------------------------
module motor_speed_loop_pi_ramp_pwm_unit import msl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  msl_in_if.sink       in_ch,
  msl_out_if.source    out_ch,
  msl_cfg_if.sink      cfg_ch
);

  cfg_regs_t regs;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  // Configuration registers
  msl_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_beat  (cfg_ch.payload),
    .regs     (regs)
  );

  // Sequencer
  msl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  msl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .regs      (regs),
    .in_item   (in_ch.payload),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
  );

endmodule
